/* src/ssqg_pkg.sv */
// ssqg_pkg: shared types, widths and the quarter-wave cosine table of the
// stepped sweep quadrature generator. Used by every module of the block.
// No dependencies.
package ssqg_pkg;

   // Field and register widths
   localparam int PHASE_W    = 24;
   localparam int SCALE_W    = 40;
   localparam int COUNT_W    = 16;
   localparam int SAMPLE_W   = 16;
   localparam int AMP_W      = 15;   // table entries run 0..16384
   localparam int TURN_W     = 16;
   localparam int POS_W      = 14;
   localparam int CSR_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;

   // Product of the turn multiply is split at this bit of angle_scale
   localparam int SPLIT_W    = 20;
   localparam int TURN_LSB   = 24;
   localparam int MODP_W     = TURN_LSB + TURN_W;   // product bits that matter

   // Quarter-wave table
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_PROD_W    = POS_W + IDX_W;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned AMP_FULL    = 64'd16384;
   localparam int              TAYLOR_MAX  = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_SPAN,
      CSR_FREQ_STEP,
      CSR_SAMPLES_PER_STEP,
      CSR_ANGLE_SCALE
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quadrant_type;

   typedef struct packed {
      logic [PHASE_W-1:0] range_span;
      logic [PHASE_W-1:0] freq_step;
      logic [COUNT_W-1:0] samples_per_step;
   } sweep_cfg_type;

   typedef logic [AMP_W-1:0] cos_table_type [0:TABLE_ENTRIES];

   // Floor quotient by shift and subtract; only evaluated while building the table.
   function automatic longint unsigned div_floor(longint unsigned num,
                                                 longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int bi = 63; bi >= 0; bi--) begin
         rem = {rem[62:0], num[bi]};
         if (rem >= den) begin
            rem     = rem - den;
            quo[bi] = 1'b1;
         end
      end
      return quo;
   endfunction

   // 16384*cos(pi/2*k/N) by an integer Taylor series in Q30, truncated.
   function automatic cos_table_type build_cos_table();
      cos_table_type   tbl;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
         x    = div_floor(64'(k) * HALF_PI_Q30, 64'(TABLE_ENTRIES));
         x2   = (x * x) >> 30;
         term = ONE_Q30;
         sum  = longint'(ONE_Q30);
         for (int n = 1; n < TAYLOR_MAX; n++) begin
            if (term != 0) begin
               term = div_floor((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
               if ((n & 1) != 0) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
         end
         if (sum < 0) begin
            v = 0;
         end else begin
            v = ($unsigned(sum) * AMP_FULL + 64'd16) >> 30;
         end
         if (v > AMP_FULL) begin
            v = AMP_FULL;
         end
         tbl[k] = AMP_W'(v);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

/* src/stepped_sweep_quadrature_generator.sv */
// stepped_sweep_quadrature_generator: top level, configuration registers and
// the sample pipeline. Depends on ssqg_pkg, ssqg_sweep and ssqg_cos_rom.
//
// Every accepted request yields one complex sample (rsp_i_sample = cos,
// rsp_q_sample = sin) of the current sweep phase, scaled by 16384. The block
// takes one request per clock and delivers one sample per clock while
// rsp_stall is low; a sample passes through five register stages, the first
// loading at the edge that takes its request: phase capture, split turn
// multiply, index calc, table read, quadrant select. The sweep state itself
// (counter, increment, phase) advances in the cycle a request is taken, so
// back-to-back requests see consecutive phases. Each stage holds its data
// while the one after it is full and stalled, so bubbles close up and
// req_stall rises only once all five stages hold samples and rsp_stall is
// high. Configuration registers are written through
// csr_write/csr_index/csr_data and should only change while no sample is in
// flight; angle_scale must be floor(2^40/range_span).
module stepped_sweep_quadrature_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ssqg_pkg::SAMPLE_W-1:0] rsp_i_sample,
   output logic signed [ssqg_pkg::SAMPLE_W-1:0] rsp_q_sample,
   // configuration
   input  logic                                 csr_write,
   input  logic [ssqg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssqg_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SW = ssqg_pkg::SPLIT_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [ssqg_pkg::PHASE_W-1:0] span_ff, fstep_ff;
   logic [ssqg_pkg::COUNT_W-1:0] sps_ff;
   logic [ssqg_pkg::SCALE_W-1:0] ascale_ff;
   ssqg_pkg::sweep_cfg_type      sweep_cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff   <= ssqg_pkg::PHASE_W'(1000);
         fstep_ff  <= ssqg_pkg::PHASE_W'(1);
         sps_ff    <= ssqg_pkg::COUNT_W'(1);
         ascale_ff <= ssqg_pkg::SCALE_W'(64'd1099511627);
      end else if (csr_write) begin
         unique case (ssqg_pkg::csr_index_type'(csr_index))
            ssqg_pkg::CSR_RANGE_SPAN:       span_ff   <= csr_data[ssqg_pkg::PHASE_W-1:0];
            ssqg_pkg::CSR_FREQ_STEP:        fstep_ff  <= csr_data[ssqg_pkg::PHASE_W-1:0];
            ssqg_pkg::CSR_SAMPLES_PER_STEP: sps_ff    <= csr_data[ssqg_pkg::COUNT_W-1:0];
            ssqg_pkg::CSR_ANGLE_SCALE:      ascale_ff <= csr_data[ssqg_pkg::SCALE_W-1:0];
            default:                        ;
         endcase
      end
   end

   assign sweep_cfg.range_span       = span_ff;
   assign sweep_cfg.freq_step        = fstep_ff;
   assign sweep_cfg.samples_per_step = sps_ff;

   // ---------------------------------------------------------------
   // Stage flow control: a stage loads when empty or when its
   // successor loads.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic ready_o, ready4, ready3, ready2, ready1, accept;

   assign ready_o   = !rsp_valid_ff || !rsp_stall;
   assign ready4    = !v4_ff || ready_o;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1)  v1_ff        <= accept;
         if (ready2)  v2_ff        <= v1_ff;
         if (ready3)  v3_ff        <= v2_ff;
         if (ready4)  v4_ff        <= v3_ff;
         if (ready_o) rsp_valid_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------
   // Sweep state and stage 1: phase of this request
   // ---------------------------------------------------------------
   logic [ssqg_pkg::PHASE_W-1:0] phase_now, st1_phase_ff;

   ssqg_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .take      (accept),
      .restart   (req_restart),
      .cfg       (sweep_cfg),
      .phase_now (phase_now)
   );

   always_ff @(posedge clock) begin
      if (ready1) st1_phase_ff <= phase_now;
   end

   // ---------------------------------------------------------------
   // Stage 2: turn = (phase*angle_scale)[39:24]. Only the low 40 product
   // bits matter, so the upper half of angle_scale needs only the low
   // 20 bits of phase and 20 bits of result.
   // ---------------------------------------------------------------
   logic [ssqg_pkg::PHASE_W+SW-1:0]                  prod_lo;
   logic [2*SW-1:0]                                  prod_hi;
   logic [ssqg_pkg::MODP_W-1:0]                      prod_lo_ff;
   logic [SW-1:0]                                    prod_hi_ff;

   assign prod_lo = (ssqg_pkg::PHASE_W+SW)'(st1_phase_ff)
                  * (ssqg_pkg::PHASE_W+SW)'(ascale_ff[SW-1:0]);
   assign prod_hi = (2*SW)'(st1_phase_ff[SW-1:0])
                  * (2*SW)'(ascale_ff[ssqg_pkg::SCALE_W-1:SW]);

   always_ff @(posedge clock) begin
      if (ready2) begin
         prod_lo_ff <= prod_lo[ssqg_pkg::MODP_W-1:0];
         prod_hi_ff <= prod_hi[SW-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: quadrant and table indices
   // ---------------------------------------------------------------
   logic [ssqg_pkg::MODP_W-1:0]     turn_sum;
   logic [ssqg_pkg::TURN_W-1:0]     turn;
   logic [ssqg_pkg::POS_W-1:0]      pos;
   logic [ssqg_pkg::IDX_PROD_W-1:0] idx_prod;
   logic [ssqg_pkg::IDX_W-1:0]      idx, cidx, idx3_ff, cidx3_ff;
   ssqg_pkg::quadrant_type          quad3_ff, quad4_ff;

   assign turn_sum = prod_lo_ff + {prod_hi_ff, SW'(0)};
   assign turn     = turn_sum[ssqg_pkg::MODP_W-1:ssqg_pkg::TURN_LSB];
   assign pos      = turn[ssqg_pkg::POS_W-1:0];
   assign idx_prod = ssqg_pkg::IDX_PROD_W'(pos)
                   * ssqg_pkg::IDX_PROD_W'(ssqg_pkg::TABLE_ENTRIES);
   assign idx      = idx_prod[ssqg_pkg::IDX_PROD_W-1:ssqg_pkg::POS_W];
   assign cidx     = ssqg_pkg::IDX_W'(ssqg_pkg::TABLE_ENTRIES) - idx;

   always_ff @(posedge clock) begin
      if (ready3) begin
         idx3_ff  <= idx;
         cidx3_ff <= cidx;
         quad3_ff <= ssqg_pkg::quadrant_type'(turn[ssqg_pkg::TURN_W-1:ssqg_pkg::POS_W]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: table read (a = T[i], b = T[N-i])
   // ---------------------------------------------------------------
   logic [ssqg_pkg::AMP_W-1:0] amp_a, amp_b;

   ssqg_cos_rom u_rom (
      .clock  (clock),
      .enable (ready4),
      .addr_a (idx3_ff),
      .addr_b (cidx3_ff),
      .data_a (amp_a),
      .data_b (amp_b)
   );

   always_ff @(posedge clock) begin
      if (ready4) quad4_ff <= quad3_ff;
   end

   // ---------------------------------------------------------------
   // Output stage: quadrant folding and sign
   // ---------------------------------------------------------------
   logic signed [ssqg_pkg::SAMPLE_W-1:0] pos_a, pos_b, neg_a, neg_b;
   logic signed [ssqg_pkg::SAMPLE_W-1:0] i_in, q_in, i_ff, q_ff;

   assign pos_a = $signed(ssqg_pkg::SAMPLE_W'(amp_a));
   assign pos_b = $signed(ssqg_pkg::SAMPLE_W'(amp_b));
   assign neg_a = -pos_a;
   assign neg_b = -pos_b;

   always_comb begin
      unique case (quad4_ff)
         ssqg_pkg::QUAD_0: begin i_in = pos_a; q_in = pos_b; end
         ssqg_pkg::QUAD_1: begin i_in = neg_b; q_in = pos_a; end
         ssqg_pkg::QUAD_2: begin i_in = neg_a; q_in = neg_b; end
         ssqg_pkg::QUAD_3: begin i_in = pos_b; q_in = neg_a; end
         default:          begin i_in = pos_a; q_in = pos_b; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready_o) begin
         i_ff <= i_in;
         q_ff <= q_in;
      end
   end

   assign rsp_i_sample = i_ff;
   assign rsp_q_sample = q_ff;

`ifndef SYNTHESIS
   // T[i] with i below N is never zero and lands on one of the two outputs
   a_sample_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_i_sample != 0 || rsp_q_sample != 0))
      else $error("both quadrature outputs zero");

   // stall upstream only when every stage is occupied and downstream stalls
   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // a restart request samples phase zero
   a_restart_phase : assert property (@(posedge clock) disable iff (reset)
      (accept && req_restart) |=> (st1_phase_ff == '0 && v1_ff))
      else $error("restart did not clear phase");
`endif

endmodule

/* src/ssqg_sweep.sv */
// ssqg_sweep: sample counter, phase increment and phase accumulator.
// Depends on ssqg_pkg.
module ssqg_sweep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          restart,
   input  ssqg_pkg::sweep_cfg_type       cfg,
   output logic [ssqg_pkg::PHASE_W-1:0]  phase_now
);

   logic [ssqg_pkg::COUNT_W-1:0] count_ff, count_in, count_base, count_inc;
   logic [ssqg_pkg::PHASE_W-1:0] incr_ff, incr_in, incr_base;
   logic [ssqg_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [ssqg_pkg::PHASE_W:0]   incr_sum, phase_sum;

   // restart clears the state ahead of this request's sample
   assign count_base = restart ? '0 : count_ff;
   assign incr_base  = restart ? '0 : incr_ff;
   assign phase_now  = restart ? '0 : phase_ff;
   assign count_inc  = count_base + ssqg_pkg::COUNT_W'(1);

   always_comb begin
      incr_sum = {1'b0, incr_base} + {1'b0, cfg.freq_step};
      if (count_inc >= cfg.samples_per_step) begin
         count_in = '0;
         if (incr_sum >= {1'b0, cfg.range_span}) begin
            incr_sum = incr_sum - {1'b0, cfg.range_span};
         end
         incr_in = incr_sum[ssqg_pkg::PHASE_W-1:0];
      end else begin
         count_in = count_inc;
         incr_in  = incr_base;
      end
      phase_sum = {1'b0, phase_now} + {1'b0, incr_in};
      if (phase_sum >= {1'b0, cfg.range_span}) begin
         phase_sum = phase_sum - {1'b0, cfg.range_span};
      end
      phase_in = phase_sum[ssqg_pkg::PHASE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         incr_ff  <= '0;
         phase_ff <= '0;
      end else if (take) begin
         count_ff <= count_in;
         incr_ff  <= incr_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* src/ssqg_cos_rom.sv */
// ssqg_cos_rom: quarter-wave cosine table, two read ports, registered data.
// Depends on ssqg_pkg (table contents).
module ssqg_cos_rom (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ssqg_pkg::IDX_W-1:0]  addr_a,
   input  logic [ssqg_pkg::IDX_W-1:0]  addr_b,
   output logic [ssqg_pkg::AMP_W-1:0]  data_a,
   output logic [ssqg_pkg::AMP_W-1:0]  data_b
);

   always_ff @(posedge clock) begin
      if (enable) begin
         data_a <= ssqg_pkg::COS_TABLE[addr_a];
         data_b <= ssqg_pkg::COS_TABLE[addr_b];
      end
   end

endmodule

/* tb/sweep_check_pkg.sv */
// sweep_check_pkg: sample predictor and result checker for the stepped sweep
// quadrature generator testbench. Depends on ssqg_pkg for widths and the
// register index and quadrant enums.
package sweep_check_pkg;

   localparam int QUARTER_POINTS = 1024;
   localparam int LOUD_LIMIT     = 100;

   typedef struct packed {
      logic signed [ssqg_pkg::SAMPLE_W-1:0] i_sample;
      logic signed [ssqg_pkg::SAMPLE_W-1:0] q_sample;
   } iq_sample_type;

   class sweep_tracker;
      int                           quarter_cos [0:QUARTER_POINTS];
      logic [ssqg_pkg::PHASE_W-1:0] span;
      logic [ssqg_pkg::PHASE_W-1:0] step;
      logic [ssqg_pkg::COUNT_W-1:0] per_step;
      logic [ssqg_pkg::SCALE_W-1:0] scale;
      logic [ssqg_pkg::COUNT_W-1:0] count;
      logic [ssqg_pkg::PHASE_W-1:0] incr;
      logic [ssqg_pkg::PHASE_W-1:0] phase;
      iq_sample_type                samples_due [$];
      int                           failures;
      int                           requests;
      int                           compared;

      function new();
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint unsigned v;
         longint          sum;
         // quarter-wave cosine, Taylor series in Q30, truncated to 16384 full scale
         for (int k = 0; k <= QUARTER_POINTS; k++) begin
            x    = (64'(k) * 64'd1686629713) / QUARTER_POINTS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 << 30;
            for (int n = 1; n < 40 && term != 0; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               v = 0;
            end else begin
               v = ($unsigned(sum) * 64'd16384 + 64'd16) >> 30;
            end
            if (v > 64'd16384) begin
               v = 64'd16384;
            end
            quarter_cos[k] = int'(v);
         end
         span     = 24'd1000;
         step     = 24'd1;
         per_step = 16'd1;
         scale    = 40'd1099511627;
         count    = '0;
         incr     = '0;
         phase    = '0;
         failures = 0;
         requests = 0;
         compared = 0;
      endfunction

      function void set_register(ssqg_pkg::csr_index_type idx,
                                 logic [ssqg_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            ssqg_pkg::CSR_RANGE_SPAN:       span     = value[ssqg_pkg::PHASE_W-1:0];
            ssqg_pkg::CSR_FREQ_STEP:        step     = value[ssqg_pkg::PHASE_W-1:0];
            ssqg_pkg::CSR_SAMPLES_PER_STEP: per_step = value[ssqg_pkg::COUNT_W-1:0];
            default:                        scale    = value[ssqg_pkg::SCALE_W-1:0];
         endcase
      endfunction

      // Expected sample for one request, then advance the sweep.
      function void take_request(bit restart);
         logic [63:0]                product;
         logic [15:0]                turn;
         ssqg_pkg::quadrant_type     quad;
         int                         idx;
         int                         a;
         int                         b;
         int                         c;
         int                         s;
         logic [ssqg_pkg::PHASE_W:0] wide;
         iq_sample_type              due;
         requests++;
         if (restart) begin
            count = '0;
            incr  = '0;
            phase = '0;
         end
         product = {40'b0, phase} * {24'b0, scale};
         turn    = product[39:24];
         quad    = ssqg_pkg::quadrant_type'(turn[15:14]);
         idx     = (int'(turn[13:0]) * QUARTER_POINTS) >> 14;
         a       = quarter_cos[idx];
         b       = quarter_cos[QUARTER_POINTS - idx];
         case (quad)
            ssqg_pkg::QUAD_0: begin
               c = a;
               s = b;
            end
            ssqg_pkg::QUAD_1: begin
               c = -b;
               s = a;
            end
            ssqg_pkg::QUAD_2: begin
               c = -a;
               s = -b;
            end
            default: begin
               c = b;
               s = -a;
            end
         endcase
         due.i_sample = c[ssqg_pkg::SAMPLE_W-1:0];
         due.q_sample = s[ssqg_pkg::SAMPLE_W-1:0];
         samples_due.push_back(due);

         count = count + 1'b1;
         if (count >= per_step) begin
            count = '0;
            wide  = {1'b0, incr} + {1'b0, step};
            if (wide >= {1'b0, span}) begin
               wide = wide - {1'b0, span};
            end
            incr = wide[ssqg_pkg::PHASE_W-1:0];
         end
         wide = {1'b0, phase} + {1'b0, incr};
         if (wide >= {1'b0, span}) begin
            wide = wide - {1'b0, span};
         end
         phase = wide[ssqg_pkg::PHASE_W-1:0];
      endfunction

      function void match_sample(logic signed [ssqg_pkg::SAMPLE_W-1:0] i_got,
                                 logic signed [ssqg_pkg::SAMPLE_W-1:0] q_got);
         iq_sample_type due;
         if (samples_due.size() == 0) begin
            failures++;
            $error("sample with no request outstanding: i_sample %0d q_sample %0d",
                   i_got, q_got);
            return;
         end
         due = samples_due.pop_front();
         compared++;
         // past the first hundred, mismatches are only counted
         if (i_got !== due.i_sample) begin
            failures++;
            if (failures <= LOUD_LIMIT)
               $error("i_sample: expected %0d, got %0d", due.i_sample, i_got);
         end
         if (q_got !== due.q_sample) begin
            failures++;
            if (failures <= LOUD_LIMIT)
               $error("q_sample: expected %0d, got %0d", due.q_sample, q_got);
         end
      endfunction

      function int pending();
         return samples_due.size();
      endfunction
   endclass

endpackage

/* tb/testbench.sv */
// testbench: drives the stepped sweep quadrature generator with sweep
// requests under changing register settings and checks every sample.
// Depends on ssqg_pkg, sweep_check_pkg and the block itself.
module testbench;

   localparam int RANDOM_REQUESTS = 1150;
   // Longest run of cycles with no request taken and no sample delivered.
   // A correct block with a 70% receiver stall almost never comes near this
   // limit, even with the quiet spells of settling and register writes added.
   localparam int QUIET_LIMIT = 2000;
   localparam logic [63:0] FULL_TURN = 64'd1 << 40;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   logic                                 req_restart = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   logic signed [ssqg_pkg::SAMPLE_W-1:0] rsp_i_sample;
   logic signed [ssqg_pkg::SAMPLE_W-1:0] rsp_q_sample;
   logic                                 csr_write   = 1'b0;
   logic [ssqg_pkg::CSR_IDX_W-1:0]       csr_index   = ssqg_pkg::CSR_RANGE_SPAN;
   logic [ssqg_pkg::CSR_DATA_W-1:0]      csr_data    = '0;

   sweep_check_pkg::sweep_tracker tracker = new();

   int issued             = 0;   // requests taken so far
   int settings           = 0;   // register settings applied
   int sender_idle_pct    = 21;
   int receiver_stall_pct = 70;
   int quiet              = 0;

   stepped_sweep_quadrature_generator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_i_sample (rsp_i_sample),
      .rsp_q_sample (rsp_q_sample),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #2 clock = ~clock;

   // Receiver back-pressure, redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Both handshakes are sampled at the rising edge, before the block's own
   // registers move. A request is predicted the moment it is taken, so the
   // predictor always sees the settings the block used for it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.take_request(req_restart);
         if (rsp_valid && !rsp_stall)
            tracker.match_sample(rsp_i_sample, rsp_q_sample);
      end
   end

   // Watchdog: any handshake clears it; a hung block trips it.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Matching angle_scale for a span; spans of 0 or 1 have none, so those get
   // an arbitrary scale.
   function automatic logic [ssqg_pkg::CSR_DATA_W-1:0] scale_for(
         logic [ssqg_pkg::PHASE_W-1:0] span);
      if (span < 2)
         return ssqg_pkg::CSR_DATA_W'({$urandom, $urandom});
      return ssqg_pkg::CSR_DATA_W'(FULL_TURN / span);
   endfunction

   // One request: optional idle cycles first, then hold until taken.
   // Idling runs in three phases: sender 21% and receiver 70%, then the
   // reverse, then no idling at all.
   task automatic send_request(input bit restart);
      if (issued < 400) begin
         sender_idle_pct    = 21;
         receiver_stall_pct = 70;
      end else if (issued < 800) begin
         sender_idle_pct    = 70;
         receiver_stall_pct = 21;
      end else begin
         sender_idle_pct    = 0;
         receiver_stall_pct = 0;
      end
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      issued++;
   endtask

   // Drop valid and wait until every sample owed has been delivered. Each
   // request yields exactly one sample, so an empty queue means idle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input ssqg_pkg::csr_index_type idx,
                            input logic [ssqg_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_setting(input logic [ssqg_pkg::PHASE_W-1:0] span,
                                input logic [ssqg_pkg::PHASE_W-1:0] step,
                                input logic [ssqg_pkg::COUNT_W-1:0] per_step,
                                input logic [ssqg_pkg::CSR_DATA_W-1:0] scale);
      settle();
      write_reg(ssqg_pkg::CSR_RANGE_SPAN, ssqg_pkg::CSR_DATA_W'(span));
      write_reg(ssqg_pkg::CSR_FREQ_STEP, ssqg_pkg::CSR_DATA_W'(step));
      write_reg(ssqg_pkg::CSR_SAMPLES_PER_STEP, ssqg_pkg::CSR_DATA_W'(per_step));
      write_reg(ssqg_pkg::CSR_ANGLE_SCALE, scale);
      settings++;
   endtask

   // Random register setting weighted towards the edges, then a burst of
   // requests with the odd restart.
   task automatic random_segment(inout int sent);
      logic [ssqg_pkg::PHASE_W-1:0]    span;
      logic [ssqg_pkg::PHASE_W-1:0]    step;
      logic [ssqg_pkg::COUNT_W-1:0]    per_step;
      logic [ssqg_pkg::CSR_DATA_W-1:0] scale;
      int                              pick;
      int                              burst;

      pick = $urandom_range(0, 9);
      case (pick)
         0:       span = 24'd2;
         1:       span = 24'hFFFFFF;
         2:       span = ssqg_pkg::PHASE_W'($urandom_range(0, 1));
         3, 4, 5: span = ssqg_pkg::PHASE_W'($urandom_range(3, 64));
         default: span = ssqg_pkg::PHASE_W'($urandom_range(2, 24'hFFFFFF));
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
         0:       step = '0;
         1:       step = 24'hFFFFFE;
         2:       step = (span > 0) ? span - 1'b1 : '0;
         3:       step = ssqg_pkg::PHASE_W'($urandom);   // often past the span
         default: step = (span > 1) ? ssqg_pkg::PHASE_W'($urandom_range(0, span - 1)) : '0;
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
         0:          per_step = '0;
         1:          per_step = 16'hFFFF;
         2:          per_step = 16'd1;
         3, 4, 5, 6: per_step = ssqg_pkg::COUNT_W'($urandom_range(1, 8));
         default:    per_step = ssqg_pkg::COUNT_W'($urandom_range(1, 16'hFFFF));
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
         7:       scale = 40'd1;
         8:       scale = 40'd549755813888;      // overshoots on all but tiny spans
         9:       scale = ssqg_pkg::CSR_DATA_W'({$urandom, $urandom});
         default: scale = scale_for(span);
      endcase

      apply_setting(span, step, per_step, scale);
      burst = $urandom_range(10, 60);
      for (int n = 0; n < burst; n++) begin
         if (n == 0)
            send_request(1'($urandom_range(0, 1)));
         else
            send_request($urandom_range(0, 99) < 3);
         sent++;
      end
   endtask

   initial begin
      int sent;
      sent = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Power-on settings: span 1000, step 1, one sample per step.
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      // Tiny span: increment and phase both wrap within a few samples.
      apply_setting(24'd5, 24'd4, 16'd1, scale_for(24'd5));
      send_request(1'b1);
      repeat (5) send_request(1'b0);

      // Step far beyond the span: one subtraction cannot bring it back.
      apply_setting(24'd7, 24'hFFFFFE, 16'd2, scale_for(24'd7));
      repeat (4) send_request(1'b0);

      // Widest span with zero samples per step and an oversized scale, so the
      // turn product overflows sixteen bits.
      apply_setting(24'hFFFFFF, 24'd3000000, 16'd0, 40'd549755813888);
      repeat (4) send_request(1'b0);

      // Smallest legal span, slowest stepping.
      apply_setting(24'd2, 24'd1, 16'hFFFF, scale_for(24'd2));
      send_request(1'b1);
      repeat (3) send_request(1'b0);

      while (sent < RANDOM_REQUESTS) random_segment(sent);

      settle();
      repeat (10) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.failures++;
         $error("%0d samples never delivered", tracker.pending());
      end

      $display("sweep run: %0d requests over %0d register settings, %0d samples compared",
               tracker.requests, settings, tracker.compared);
      $display("sweep run: idling 21/70, then 70/21, then none (sender/receiver %%)");
      if (tracker.failures == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
